/* design/cram16_block_video_decoder_defines.svh */
// Assertion macros for the CRAM block decoder.
`ifndef CRAM16_BLOCK_VIDEO_DECODER_DEFINES_SVH
`define CRAM16_BLOCK_VIDEO_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CRAM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRAM_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CRAM_ASSERT(label, clk, rst_n, prop, msg)
`define CRAM_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* design/cram_pkg.sv */
`timescale 1ns / 1ps
package cram_pkg;
	localparam int MaxDim = 4096;
	localparam int CountBits = 24;
	localparam int DimBits = 13;
	localparam int BlkBits = 21;
	localparam int ColBits = 10;
	localparam int QDepth = 2;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_TRUNC = 2'd2;

	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// Work handed from front to back.
	typedef struct packed {
		logic                 emit;    // 16 pixels of a colour block
		logic                 fill;
		logic                 eight;
		logic [15:0]          flags;
		logic [8:0][15:0]     words;   // fill word, or colour pairs
		logic [ColBits-1:0]   col;
		logic [ColBits-1:0]   row;
		logic [1:0]           tail;    // KIND_DONE, KIND_TRUNC or KIND_PIXEL for none
		logic [CountBits-1:0] count;
		logic [DimBits-1:0]   w;
		logic [DimBits-1:0]   h;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PIX,
		BK_TAIL
	} bk_state_t;

	function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v);
		if (v == '0) return DimBits'(1);
		if (v > DimBits'(MaxDim)) return DimBits'(MaxDim);
		return v;
	endfunction
endpackage

/* design/cram_front.sv */
`timescale 1ns / 1ps
`include "cram16_block_video_decoder_defines.svh"
module cram_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          code_byte,
	input  logic                buffer_end,
	input  logic [12:0]         w_reg,
	input  logic [12:0]         h_reg,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output cram_pkg::cmd_t      cmd
);
	import cram_pkg::*;

	logic [7:0]           held_q [18];
	logic [4:0]           cnt_q;
	logic [BlkBits-1:0]   blk_q;
	logic [ColBits-1:0]   col_q, row_q;
	logic [CountBits-1:0] used_q;
	logic                 done_q;
	logic [DimBits-1:0]   w_q, h_q;
	logic [10:0]          cols_q, rows_q;
	logic [BlkBits:0]     total_q;
	logic                 busy_q;     // block position search in progress
	logic                 dims_ok_q;
	logic                 stale_q;    // column count changed since the position was found

	logic                 acc;
	logic [4:0]           cnt_n;
	logic [4:0]           need;
	logic                 group_done, is_skip;
	logic [BlkBits-1:0]   blk_n;
	logic [CountBits-1:0] used_n;
	logic [DimBits-1:0]   wc, hc;
	cmd_t                 c;

	assign wc = clamp_dim(w_reg);
	assign hc = clamp_dim(h_reg);

	// The grid size is a product, registered ahead of use; position after a jump is
	// found by repeated subtraction of the column count in busy cycles.
	logic [BlkBits:0]   rem_q;
	logic [ColBits:0]   rrow_q;
	assign in_stall = !dims_ok_q || (w_q != wc) || (h_q != hc) || busy_q || !cmd_ready;
	assign acc = in_valid && !in_stall;

	always_comb begin
		logic [7:0] hb1, hb3;
		cnt_n = cnt_q + 5'd1;
		hb1 = (cnt_q == 5'd1) ? code_byte : held_q[1];
		hb3 = (cnt_q == 5'd3) ? code_byte : held_q[3];
		need = 5'd0;
		if (cnt_n >= 5'd2) begin
			if (hb1 < 8'h80) need = (cnt_n >= 5'd4 && hb3[7]) ? 5'd18 : 5'd6;
			else need = 5'd2;
		end
		group_done = (need != 5'd0) && (cnt_n >= need);
		is_skip = (hb1 >= 8'h84) && (hb1 < 8'h88);
		if (is_skip)
			blk_n = blk_q + BlkBits'({hb1[1:0], (cnt_q == 5'd0) ? code_byte : held_q[0]});
		else
			blk_n = blk_q + BlkBits'(1);
		used_n = (used_q == {CountBits{1'b1}}) ? used_q : used_q + CountBits'(1);
	end

	always_comb begin
		logic [7:0] hb [18];
		for (int i = 0; i < 18; i++)
			hb[i] = (5'(i) == cnt_q) ? code_byte : held_q[i];
		c = '0;
		c.flags = {hb[1], hb[0]};
		c.fill = hb[1] >= 8'h80;
		c.eight = !c.fill && hb[3][7];
		c.words[0] = {hb[1], hb[0]};
		for (int p = 0; p < 8; p++) c.words[p+1] = {hb[2*p+3], hb[2*p+2]};
		c.col = col_q;
		c.row = row_q;
		c.w = w_q;
		c.h = h_q;
		c.tail = KIND_PIXEL;
		c.count = '0;
		if (!done_q) begin
			if (cnt_q == 5'd0 && {1'b0, blk_q} >= total_q) begin
				c.tail = KIND_DONE;
				c.count = used_q;
			end else if (group_done) begin
				c.emit = !is_skip;
				if ({1'b0, blk_n} >= total_q) begin
					c.tail = KIND_DONE;
					c.count = used_n;
				end else if (buffer_end) c.tail = KIND_TRUNC;
			end else if (buffer_end) c.tail = KIND_TRUNC;
		end
	end

	assign cmd_valid = acc && (c.emit || c.tail != KIND_PIXEL);
	assign cmd = c;

	always_ff @(posedge clk) begin
		if (acc && !done_q && !(cnt_q == 5'd0 && {1'b0, blk_q} >= total_q) && cnt_q < 5'd18)
			held_q[cnt_q] <= code_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; blk_q <= '0; col_q <= '0; row_q <= '0; used_q <= '0;
			done_q <= 1'b0; busy_q <= 1'b0; dims_ok_q <= 1'b0; stale_q <= 1'b0;
			w_q <= '0; h_q <= '0; cols_q <= '0; rows_q <= '0; total_q <= '0;
			rem_q <= '0; rrow_q <= '0;
		end else begin
			// Track the register values; a change stalls the input until the grid is registered anew.
			w_q <= wc;
			h_q <= hc;
			cols_q <= 11'((wc + 13'd3) >> 2);
			rows_q <= 11'((hc + 13'd3) >> 2);
			total_q <= (BlkBits+1)'(cols_q) * (BlkBits+1)'(rows_q);
			dims_ok_q <= (w_q == wc) && (h_q == hc) && (cols_q == 11'((w_q + 13'd3) >> 2))
				&& (rows_q == 11'((h_q + 13'd3) >> 2))
				&& (total_q == (BlkBits+1)'(cols_q) * (BlkBits+1)'(rows_q));
			if (busy_q) begin
				if (rem_q >= {{(BlkBits-10){1'b0}}, cols_q}) begin
					rem_q <= rem_q - {{(BlkBits-10){1'b0}}, cols_q};
					rrow_q <= rrow_q + 1'b1;
				end else begin
					col_q <= ColBits'(rem_q);
					row_q <= ColBits'(rrow_q);
					busy_q <= 1'b0;
					stale_q <= 1'b0;
				end
			end else if (acc) begin
				if (done_q) begin
					if (buffer_end) begin
						done_q <= 1'b0; cnt_q <= '0; blk_q <= '0;
						col_q <= '0; row_q <= '0; used_q <= '0;
					end
				end else if (cnt_q == 5'd0 && {1'b0, blk_q} >= total_q) begin
					if (buffer_end) begin
						blk_q <= '0; col_q <= '0; row_q <= '0; used_q <= '0;
					end else done_q <= 1'b1;
				end else if (group_done && {1'b0, blk_n} >= total_q) begin
					cnt_q <= '0;
					if (buffer_end) begin
						blk_q <= '0; col_q <= '0; row_q <= '0; used_q <= '0;
					end else begin
						done_q <= 1'b1; blk_q <= blk_n; used_q <= used_n;
					end
				end else if (buffer_end) begin
					cnt_q <= '0; blk_q <= '0; col_q <= '0; row_q <= '0; used_q <= '0;
				end else if (group_done) begin
					cnt_q <= '0;
					blk_q <= blk_n;
					used_q <= used_n;
					if (!is_skip && !stale_q && (11'(col_q) + 11'd1 < cols_q))
						col_q <= col_q + 1'b1;
					else if (!is_skip && !stale_q) begin
						col_q <= '0; row_q <= row_q + 1'b1;
					end else begin
						rem_q <= {1'b0, blk_n};
						rrow_q <= '0;
						busy_q <= 1'b1;
					end
				end else begin
					cnt_q <= (cnt_q < 5'd18) ? cnt_n : cnt_q;
					used_q <= used_n;
				end
			end
			// After a new width the next step must search the position afresh.
			if (cols_q != 11'((wc + 13'd3) >> 2)) stale_q <= 1'b1;
		end
	end

	`CRAM_NEVER(a_no_cmd_busy, clk, arst_n, cmd_valid && busy_q, "command during position search")
	`CRAM_NEVER(a_cnt_range, clk, arst_n, cnt_q > 5'd17, "held count out of range")
	`CRAM_ASSERT(a_done_quiet, clk, arst_n, (done_q && !acc) |=> done_q, "done cleared without a word")
endmodule

/* design/cram_queue.sv */
`timescale 1ns / 1ps
module cram_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  cram_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output cram_pkg::cmd_t rd_data
);
	import cram_pkg::*;
	cmd_t       mem_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] n_q;
	assign wr_ready = n_q != 2'(QDepth);
	assign rd_valid = n_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	always_ff @(posedge clk) if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; n_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= !wp_q;
			if (rd_valid && rd_ready) rp_q <= !rp_q;
			n_q <= n_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end
endmodule

/* design/cram_back.sv */
`timescale 1ns / 1ps
`include "cram16_block_video_decoder_defines.svh"
module cram_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  cram_pkg::cmd_t cmd,
	output logic           valid,
	input  logic           stall,
	output logic [1:0]     kind,
	output logic [11:0]    pixel_x,
	output logic [11:0]    line_from_bottom,
	output logic           inside_frame,
	output logic [7:0]     chan_high,
	output logic [7:0]     chan_mid,
	output logic [7:0]     chan_low,
	output logic [23:0]    bytes_consumed,
	output logic           run_last
);
	import cram_pkg::*;
	bk_state_t st_q, st_n;
	cmd_t      c_q;
	logic [3:0] pix_q;
	logic       load, adv, ov_free;
	logic [15:0] wd;
	logic [11:0] x, y;
	logic [1:0]  r, cc;
	logic [3:0]  sel;

	assign ov_free = !valid || !stall;
	assign r = pix_q[3:2];
	assign cc = pix_q[1:0];
	assign x = {c_q.col, cc};
	assign y = {c_q.row, r};
	always_comb begin
		sel = c_q.eight ? {1'b0, r[1], cc[1], 1'b0} : 4'd0;
		if (c_q.fill) wd = c_q.words[0];
		else if (c_q.flags[pix_q]) wd = c_q.words[sel + 4'd1];
		else wd = c_q.words[sel + 4'd2];
	end

	always_comb begin
		st_n = st_q;
		load = 1'b0;
		adv = 1'b0;
		unique case (st_q)
			BK_IDLE: if (cmd_valid) begin
				load = 1'b1;
				st_n = cmd.emit ? BK_PIX : BK_TAIL;
			end
			BK_PIX: if (ov_free) begin
				adv = 1'b1;
				if (pix_q == 4'd15) st_n = (c_q.tail != KIND_PIXEL) ? BK_TAIL : BK_IDLE;
			end
			BK_TAIL: if (ov_free) begin
				adv = 1'b1;
				st_n = BK_IDLE;
			end
			default: st_n = BK_IDLE;
		endcase
	end
	assign cmd_ready = (st_q == BK_IDLE);

	always_ff @(posedge clk) begin
		if (load) c_q <= cmd;
		if (adv) begin
			run_last <= (st_q == BK_TAIL) || (pix_q == 4'd15 && c_q.tail == KIND_PIXEL);
			if (st_q == BK_PIX) begin
				kind <= KIND_PIXEL;
				pixel_x <= x;
				line_from_bottom <= y;
				inside_frame <= ({1'b0, x} < c_q.w) && ({1'b0, y} < c_q.h);
				chan_high <= {wd[14:10], 3'b0};
				chan_mid <= {wd[9:5], 3'b0};
				chan_low <= {wd[4:0], 3'b0};
				bytes_consumed <= '0;
			end else begin
				kind <= c_q.tail;
				pixel_x <= '0; line_from_bottom <= '0; inside_frame <= 1'b0;
				chan_high <= '0; chan_mid <= '0; chan_low <= '0;
				bytes_consumed <= (c_q.tail == KIND_DONE) ? c_q.count : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE; pix_q <= '0; valid <= 1'b0;
		end else begin
			st_q <= st_n;
			if (load) pix_q <= '0;
			else if (adv && st_q == BK_PIX) pix_q <= pix_q + 4'd1;
			if (adv) valid <= 1'b1;
			else if (!stall) valid <= 1'b0;
		end
	end

	`CRAM_NEVER(a_load_busy, clk, arst_n, load && st_q != BK_IDLE, "load while busy")
	`CRAM_ASSERT(a_pix_wrap, clk, arst_n, (st_q == BK_PIX && adv && pix_q == 4'd15) |=> st_q != BK_PIX, "wrapped")
	`CRAM_NEVER(a_adv_stalled, clk, arst_n, adv && valid && stall, "overwrote a held word")
endmodule

/* design/cram16_block_video_decoder.sv */
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// in       in_valid/in_stall   code_byte, buffer_end
// out      valid/stall         kind .. run_last
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
// The front takes a byte whenever it does not stall; after a skip, or the first block
// after a new width, the input stalls while the new position is searched row by row.
// In the back part a colour block gives 16 pixel words and a status one word.
// The front stalls while the two-entry command queue is full, and after a change of the
// frame registers until the new grid is set up. Reset is asynchronous, leaves 320x240.
module cram16_block_video_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code_byte,
	input  logic        buffer_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output logic        valid,
	input  logic        stall,
	output logic [1:0]  kind,
	output logic [11:0] pixel_x,
	output logic [11:0] line_from_bottom,
	output logic        inside_frame,
	output logic [7:0]  chan_high,
	output logic [7:0]  chan_mid,
	output logic [7:0]  chan_low,
	output logic [23:0] bytes_consumed,
	output logic        run_last
);
	import cram_pkg::*;
	logic [12:0] w_q, h_q;
	cmd_t fc, bc;
	logic fv, fr, bv, br;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 13'd320; h_q <= 13'd240;
		end else if (cfg_valid) begin
			if (cfg_index == REG_WIDTH) w_q <= cfg_data;
			else h_q <= cfg_data;
		end
	end
	cram_front u_front (.clk, .arst_n, .in_valid, .in_stall, .code_byte, .buffer_end,
		.w_reg(w_q), .h_reg(h_q), .cmd_valid(fv), .cmd_ready(fr), .cmd(fc));
	cram_queue u_queue (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fc),
		.rd_valid(bv), .rd_ready(br), .rd_data(bc));
	cram_back u_back (.clk, .arst_n, .cmd_valid(bv), .cmd_ready(br), .cmd(bc), .valid, .stall,
		.kind, .pixel_x, .line_from_bottom, .inside_frame, .chan_high, .chan_mid, .chan_low,
		.bytes_consumed, .run_last);
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import cram_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] x;
		logic [11:0] y;
		logic        ins;
		logic [7:0]  ch;
		logic [7:0]  cm;
		logic [7:0]  cl;
		logic [23:0] cnt;
		logic        last;
	} pix_word_t;

	class cram_scoreboard;
		logic [12:0] width_reg = 13'd320;
		logic [12:0] height_reg = 13'd240;
		bit          frame_done;
		logic [7:0]  held [18];
		int          held_n;
		logic [20:0] blk;
		int          bcol, brow;
		logic [23:0] used;
		pix_word_t   pending_q [$];
		int          errors;
		int          words_seen;

		function int dim_of(logic [12:0] v);
			if (v == 0) return 1;
			if (v > MaxDim) return MaxDim;
			return v;
		endfunction

		function void restart();
			frame_done = 0;
			held_n = 0;
			blk = 0;
			bcol = 0;
			brow = 0;
			used = 0;
		endfunction

		function void push_status(logic [1:0] k, logic [23:0] c);
			pix_word_t r;
			r = '0;
			r.kind = k;
			r.cnt = c;
			pending_q.push_back(r);
		endfunction

		function logic [15:0] word_at(int i);
			return {held[i + 1], held[i]};
		endfunction

		function void push_block(int w, int h);
			pix_word_t   r;
			logic [15:0] flags, colour;
			bit          eight, fill;
			int          x, y, q;
			flags = {held[1], held[0]};
			fill = held[1] >= 8'h80;
			eight = !fill && held[3][7];
			for (int ln = 0; ln < 4; ln++) begin
				for (int c = 0; c < 4; c++) begin
					x = bcol * 4 + c;
					y = brow * 4 + ln;
					q = eight ? ((ln >> 1) * 2 + (c >> 1)) : 0;
					if (fill) colour = flags;
					else if (flags[ln * 4 + c]) colour = word_at(2 + 4 * q);
					else colour = word_at(4 + 4 * q);
					r = '0;
					r.kind = KIND_PIXEL;
					r.x = x[11:0];
					r.y = y[11:0];
					r.ins = (x < w) && (y < h);
					r.ch = {colour[14:10], 3'b000};
					r.cm = {colour[9:5], 3'b000};
					r.cl = {colour[4:0], 3'b000};
					pending_q.push_back(r);
				end
			end
		endfunction

		// Works out every word that one accepted code byte should produce.
		function void note_byte(logic [7:0] byt, logic fin);
			int w, h, cols, total, need, start_n;
			w = dim_of(width_reg);
			h = dim_of(height_reg);
			cols = (w + 3) / 4;
			total = cols * ((h + 3) / 4);
			need = 0;
			start_n = pending_q.size();
			if (frame_done) begin
				if (fin) restart();
				return;
			end
			if (held_n == 0 && blk >= total) begin
				push_status(KIND_DONE, used);
				if (fin) restart();
				else frame_done = 1;
				pending_q[$].last = 1;
				return;
			end
			if (used != 24'hFFFFFF) used++;
			if (held_n < 18) begin
				held[held_n] = byt;
				held_n++;
			end
			if (held_n >= 2) begin
				if (held[1] < 8'h80) need = (held_n >= 4 && held[3][7]) ? 18 : 6;
				else need = 2;
			end
			if (need != 0 && held_n >= need) begin
				if (held[1] >= 8'h84 && held[1] < 8'h88) begin
					blk = blk + {held[1][1:0], held[0]};
				end else begin
					push_block(w, h);
					blk = blk + 1;
				end
				held_n = 0;
				bcol = (blk % cols) & 10'h3FF;
				brow = (blk / cols) & 10'h3FF;
				if (blk >= total) begin
					push_status(KIND_DONE, used);
					if (fin) restart();
					else frame_done = 1;
				end else if (fin) begin
					push_status(KIND_TRUNC, 0);
					restart();
				end
			end else if (fin) begin
				push_status(KIND_TRUNC, 0);
				restart();
			end
			if (pending_q.size() > start_n) pending_q[$].last = 1;
		endfunction

		function void check_word(pix_word_t got);
			pix_word_t exp_w;
			words_seen++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected word kind=%0d x=%0d y=%0d", $time, got.kind,
					got.x, got.y);
				errors++;
				return;
			end
			exp_w = pending_q.pop_front();
			if (got !== exp_w) begin
				$display("%0t: mismatch expected kind=%0d x=%0d y=%0d in=%0d rgb=%h/%h/%h cnt=%0d last=%0d",
					$time, exp_w.kind, exp_w.x, exp_w.y, exp_w.ins, exp_w.ch, exp_w.cm,
					exp_w.cl, exp_w.cnt, exp_w.last);
				$display("%0t:          actual   kind=%0d x=%0d y=%0d in=%0d rgb=%h/%h/%h cnt=%0d last=%0d",
					$time, got.kind, got.x, got.y, got.ins, got.ch, got.cm, got.cl,
					got.cnt, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  code_byte = 0;
	logic        buffer_end = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = REG_WIDTH;
	logic [12:0] cfg_data = 0;
	logic        valid;
	logic        stall = 0;
	logic [1:0]  kind;
	logic [11:0] pixel_x, line_from_bottom;
	logic        inside_frame;
	logic [7:0]  chan_high, chan_mid, chan_low;
	logic [23:0] bytes_consumed;
	logic        run_last;

	cram_scoreboard sb = new;
	int send_idle_pct, recv_stall_pct;
	int hold_request, hold_left;
	int bytes_sent;
	int cur_w = 320, cur_h = 240;

	cram16_block_video_decoder dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

	// The receiver stall; a long hold-off lets the decoder back up to its input.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall <= 1'b1;
		end else begin
			stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && valid && !stall)
			sb.check_word({kind, pixel_x, line_from_bottom, inside_frame, chan_high,
				chan_mid, chan_low, bytes_consumed, run_last});
	end

	task send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		buffer_end <= fin;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b, fin);
		bytes_sent++;
		@(negedge clk);
	endtask

	task drain(input int extra);
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
		@(negedge clk);
	endtask

	// Only called once the decoder has gone quiet.
	task write_reg(input logic [0:0] idx, input logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_WIDTH) sb.width_reg = val;
		else sb.height_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task set_frame(input logic [12:0] w, input logic [12:0] h);
		drain(1100);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cur_w = (w == 0) ? 1 : (w > MaxDim ? MaxDim : w);
		cur_h = (h == 0) ? 1 : (h > MaxDim ? MaxDim : h);
	endtask

	// Sends whole frames of well-formed code groups with random content, with
	// the odd early buffer end and some trailing bytes after a finished frame.
	task random_frames(input int budget);
		logic [7:0] grp [18];
		int remaining, len, sel, cut, skip_n, junk;
		bit fin;
		while (budget > 0) begin
			remaining = ((cur_w + 3) / 4) * ((cur_h + 3) / 4);
			fin = 0;
			while (!fin) begin
				foreach (grp[i]) grp[i] = $urandom_range(255);
				sel = $urandom_range(9);
				if (sel < 2) begin
					skip_n = (remaining < 1023) ? $urandom_range(remaining + 1) :
						$urandom_range(1023);
					if ($urandom_range(9) == 0) skip_n = $urandom_range(1023);
					grp[0] = skip_n[7:0];
					grp[1] = 8'h84 + skip_n[9:8];
					len = 2;
					remaining -= skip_n;
				end else begin
					if (sel < 5) begin
						grp[1] = (grp[1] >= 8'h84 && grp[1] < 8'h88) ? 8'hFF : grp[1] | 8'h80;
						len = 2;
					end else if (sel < 8) begin
						grp[1][7] = 1'b0;
						grp[3][7] = 1'b0;
						len = 6;
					end else begin
						grp[1][7] = 1'b0;
						grp[3][7] = 1'b1;
						len = 18;
					end
					remaining--;
				end
				cut = len;
				if ($urandom_range(19) == 0 || budget <= len) begin
					cut = $urandom_range(len, 1);
					fin = 1;
				end else if (remaining <= 0) begin
					fin = 1;
				end
				for (int i = 0; i < cut; i++) begin
					send_byte(grp[i], fin && (i == cut - 1) &&
						(cut < len || remaining > 0 || $urandom_range(1)));
					budget--;
				end
				if (fin && cut == len && remaining <= 0 && !buffer_end) begin
					junk = $urandom_range(3, 1);
					for (int i = 0; i < junk; i++)
						send_byte($urandom_range(255), i == junk - 1);
				end
			end
		end
	endtask

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Reset size: a fill block, a two-colour block, an eight-colour block,
		// a skip of zero, then a buffer that stops inside a code group.
		send_byte(8'h34, 0); send_byte(8'h92, 0);
		send_byte(8'hA5, 0); send_byte(8'h3C, 0);
		send_byte(8'h1F, 0); send_byte(8'h7C, 0);
		send_byte(8'hE0, 0); send_byte(8'h03, 0);
		send_byte(8'hFF, 0); send_byte(8'h00, 0);
		for (int i = 0; i < 16; i++) send_byte((i % 4 == 1) ? 8'hFF : 8'h00, 0);
		send_byte(8'h00, 0); send_byte(8'h84, 0);
		send_byte(8'h11, 1);

		// One column, tallest grid: a partial edge block, then a skip to
		// the end, then ignored bytes that close the buffer.
		set_frame(13'd0, 13'd8191);
		send_byte(8'hFF, 0); send_byte(8'hFF, 0);
		send_byte(8'hFF, 0); send_byte(8'h87, 0);
		send_byte(8'h55, 0); send_byte(8'hAA, 1);

		// Grid shrunk while a frame is under way.
		set_frame(13'd8, 13'd8);
		send_byte(8'h00, 0); send_byte(8'h80, 0);
		send_byte(8'hFF, 0); send_byte(8'h83, 0);
		set_frame(13'd4, 13'd4);
		send_byte(8'h77, 1);

		set_frame(13'd8, 13'd8);
		random_frames(40);
		send_idle_pct = 69;
		set_frame(13'd5, 13'd7);
		random_frames(40);
		send_idle_pct = 0;
		recv_stall_pct = 69;
		set_frame(13'd16, 13'd4);
		random_frames(40);
		send_idle_pct = 18;
		recv_stall_pct = 18;
		set_frame(13'd4096, 13'd1);
		random_frames(30);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_frame(13'd12, 13'd9);
		hold_request = 400;
		random_frames(50);
		send_idle_pct = 69;
		recv_stall_pct = 69;
		set_frame(13'd1, 13'd4096);
		random_frames(20);

		drain(1100);
		$display("Sent %0d code bytes over eight frame sizes and checked %0d output words.",
			bytes_sent, sb.words_seen);
		$display("Covered fill, two-colour, eight-colour, skips, truncation and regrid.");
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
